/* rtl/mpbf_pkg.sv */
// Shared types and constants for the multipart boundary finder.
package mpbf_pkg;

    localparam int BOUNDARY_MAX_BYTES_DEF = 32;
    localparam int FILL_W                 = 6;
    localparam int BND_WORDS              = 4;
    localparam int ADDR_W                 = 6;
    localparam int DATA_W                 = 64;
    localparam logic [7:0] DASH           = 8'h2D;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FOUND = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_BND0 = 3'd0,
        REG_BND1 = 3'd1,
        REG_BND2 = 3'd2,
        REG_BND3 = 3'd3,
        REG_LEN  = 3'd4,
        REG_KEEP = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic              load;
        logic [FILL_W-1:0] fill;
        logic [FILL_W-1:0] width;
    } t_cell_ctrl;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
    } t_result;

endpackage

/* rtl/mpbf_cell.sv */
// One window cell: holds one byte, takes the new byte or its neighbor's, and compares.
module mpbf_cell
    import mpbf_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_shift,
    input  logic [7:0] i_new_byte,
    input  logic [7:0] i_next_byte,
    input  logic [7:0] i_ref_byte,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    localparam logic [FILL_W-1:0] IDX = FILL_W'(CELL_IDX);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // The value this cell holds once the incoming byte has been appended.
    assign o_byte = (i_ctrl.load && (i_ctrl.fill == IDX)) ? i_new_byte : r_byte;
    assign o_hit  = (o_byte == i_ref_byte) || (IDX >= i_ctrl.width);

    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.load) begin
            n_byte = i_shift ? i_next_byte : o_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

/* rtl/mpbf_out_buf.sv */
// Two-entry output buffer that lets a new item in while a result waits.
module mpbf_out_buf
    import mpbf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    w_pop;

    assign w_pop   = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end
            r_main_valid <= 1'b1;
        end else if (w_pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !w_pop) begin
                r_skid <= i_res;
            end else begin
                r_main <= i_res;
            end
        end
    end

endmodule

/* rtl/multipart_boundary_finder.sv */
// Top level of the multipart boundary finder with its register port and cell chain.
// A result is written into the output buffer register and then offered on o_valid.
// Throughput: one item per cycle while o_stall is low; the append, window compare
// and cell chain shift are combinational, and the output buffer absorbs one stall.
// Reset: the window is emptied, the boundary is all zero, length 1, keep mode on,
// and the output buffer is empty. Window bytes themselves are not cleared.
module multipart_boundary_finder
    import mpbf_pkg::*;
#(
    parameter int BOUNDARY_MAX_BYTES = BOUNDARY_MAX_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_stream_closed,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_result_kind,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_run
);

    localparam int WIN_DEPTH = BOUNDARY_MAX_BYTES + 2;
    localparam logic [FILL_W-1:0] LEN_MAX = FILL_W'(BOUNDARY_MAX_BYTES);

    logic [DATA_W-1:0] r_bnd [BND_WORDS];
    logic [FILL_W-1:0] r_len;
    logic              r_keep;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;

    t_reg_idx          w_reg_idx;
    logic              w_cfg_wr;
    logic [8*BND_WORDS*8-1:0] w_bnd_flat;
    logic [FILL_W-1:0] w_len;
    logic [FILL_W-1:0] w_fill_p;
    logic              w_full;
    logic              w_match;
    logic              w_accept;
    logic              w_buf_full;
    logic              w_shift;
    logic              w_push;
    t_result           w_res;
    t_result           w_out;
    t_cell_ctrl        w_ctrl;
    logic [7:0]        w_byte [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] w_hit;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[5:3]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < BND_WORDS; w++) begin
                r_bnd[w] <= '0;
            end
            r_len  <= FILL_W'(1);
            r_keep <= 1'b1;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_BND0: r_bnd[0] <= pwdata;
                REG_BND1: r_bnd[1] <= pwdata;
                REG_BND2: r_bnd[2] <= pwdata;
                REG_BND3: r_bnd[3] <= pwdata;
                REG_LEN:  r_len    <= pwdata[FILL_W-1:0];
                REG_KEEP: r_keep   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_BND0: prdata = r_bnd[0];
            REG_BND1: prdata = r_bnd[1];
            REG_BND2: prdata = r_bnd[2];
            REG_BND3: prdata = r_bnd[3];
            REG_LEN:  prdata = {{(DATA_W-FILL_W){1'b0}}, r_len};
            REG_KEEP: prdata = {{(DATA_W-1){1'b0}}, r_keep};
            default:  prdata = '0;
        endcase
    end

    assign w_bnd_flat = {r_bnd[3], r_bnd[2], r_bnd[1], r_bnd[0]};

    // A zero length acts as one; anything beyond the window acts as the maximum.
    assign w_len = (r_len == '0) ? FILL_W'(1) : ((r_len > LEN_MAX) ? LEN_MAX : r_len);

    assign w_accept = i_valid && !w_buf_full;
    assign o_stall  = w_buf_full;

    assign w_ctrl.load  = w_accept && !i_stream_closed;
    assign w_ctrl.fill  = r_fill;
    assign w_ctrl.width = w_len + FILL_W'(2);

    genvar k;
    generate
        for (k = 0; k < WIN_DEPTH; k++) begin : g_cell
            logic [7:0] w_next;
            logic [7:0] w_ref;
            if (k == WIN_DEPTH - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_link
                assign w_next = w_byte[k+1];
            end
            if (k < 2) begin : g_dash
                assign w_ref = DASH;
            end else begin : g_bnd
                assign w_ref = w_bnd_flat[8*(k-2) +: 8];
            end
            mpbf_cell #(
                .CELL_IDX (k)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_shift     (w_shift),
                .i_new_byte  (i_data_byte),
                .i_next_byte (w_next),
                .i_ref_byte  (w_ref),
                .o_byte      (w_byte[k]),
                .o_hit       (w_hit[k])
            );
        end
    endgenerate

    assign w_fill_p = r_fill + FILL_W'(1);
    assign w_full   = (w_fill_p >= w_ctrl.width);
    assign w_match  = w_full && (&w_hit);

    always_comb begin
        n_fill     = r_fill;
        w_shift    = 1'b0;
        w_push     = 1'b0;
        w_res.kind = KIND_BYTE;
        w_res.data = '0;
        w_res.last = 1'b1;
        if (w_accept) begin
            if (i_stream_closed) begin
                n_fill     = '0;
                w_push     = 1'b1;
                w_res.kind = KIND_END;
            end else if (!w_full) begin
                n_fill = w_fill_p;
            end else if (w_match) begin
                n_fill     = '0;
                w_push     = 1'b1;
                w_res.kind = KIND_FOUND;
            end else begin
                w_shift = 1'b1;
                if (r_keep) begin
                    w_push     = 1'b1;
                    w_res.data = w_byte[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    mpbf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_full  (w_buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_out)
    );

    assign o_result_kind = w_out.kind;
    assign o_out_byte    = w_out.data;
    assign o_last_of_run = w_out.last;

endmodule

/* tb/sv/tb_multipart_boundary_finder.sv */
// Self-checking testbench for the multipart boundary finder with byte traffic and checks.
module tb_multipart_boundary_finder;
    import mpbf_pkg::*;

    localparam int WIN_DEPTH = BOUNDARY_MAX_BYTES_DEF + 2;
    localparam int REG_STRIDE = 8;
    localparam int REG_SLOTS = (2 ** ADDR_W) / REG_STRIDE;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [8:0] CLOSE_ITEM = 9'h100;

    typedef enum {STYLE_RANDOM, STYLE_ZERO, STYLE_ONES, STYLE_DASHES} t_boundary_style;

    class t_boundary_scoreboard;
        logic [DATA_W-1:0] bnd_words [BND_WORDS];
        logic [5:0]        len_reg;
        logic              keep_reg;
        logic [7:0]        window [WIN_DEPTH];
        int                fill;
        t_result           expected_results [$];
        int                errors;
        int                items;
        int                bytes_passed;
        int                founds;
        int                ends;

        function new();
            foreach (bnd_words[w]) bnd_words[w] = '0;
            len_reg = 6'd1;
            keep_reg = 1'b1;
            fill = 0;
            errors = 0;
            items = 0;
            bytes_passed = 0;
            founds = 0;
            ends = 0;
        endfunction

        function void write_cfg(int idx, logic [DATA_W-1:0] value);
            if (idx <= REG_BND3) begin
                bnd_words[idx] = value;
            end else if (idx == REG_LEN) begin
                len_reg = value[5:0];
            end else if (idx == REG_KEEP) begin
                keep_reg = value[0];
            end
        endfunction

        function int used_len();
            int n = len_reg;
            if (n == 0) begin
                n = 1;
            end
            if (n > BOUNDARY_MAX_BYTES_DEF) begin
                n = BOUNDARY_MAX_BYTES_DEF;
            end
            return n;
        endfunction

        function logic [7:0] bnd_byte(int i);
            return bnd_words[i / 8][(i % 8) * 8 +: 8];
        endfunction

        function void queue_result(t_kind kind, logic [7:0] data);
            t_result r;
            r.kind = kind;
            r.data = data;
            r.last = 1'b1;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void note_item(logic [7:0] data, logic closed);
            int len;
            bit hit;
            logic [7:0] head;
            items++;
            if (closed) begin
                fill = 0;
                ends++;
                queue_result(KIND_END, 8'h00);
                return;
            end
            len = used_len();
            if (fill >= WIN_DEPTH) begin
                fill = WIN_DEPTH - 1;
            end
            window[fill] = data;
            fill++;
            if (fill < len + 2) begin
                return;
            end
            hit = (window[0] == DASH) && (window[1] == DASH);
            for (int i = 0; i < len; i++) begin
                if (window[2 + i] != bnd_byte(i)) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                fill = 0;
                founds++;
                queue_result(KIND_FOUND, 8'h00);
                return;
            end
            head = window[0];
            for (int i = 0; i < fill - 1; i++) begin
                window[i] = window[i + 1];
            end
            fill--;
            if (keep_reg) begin
                bytes_passed++;
                queue_result(KIND_BYTE, head);
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            t_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d byte %h", $time, kind, data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: result_kind expected %0d, actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (data !== want.data) begin
                $display("%0t: out_byte expected %h, actual %h", $time, want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last_of_run expected %b, actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [7:0]        i_data_byte = 8'h00;
    logic              i_stream_closed = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_result_kind;
    logic [7:0]        o_out_byte;
    logic              o_last_of_run;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    t_boundary_scoreboard board = new();

    multipart_boundary_finder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_stream_closed (i_stream_closed),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_kind   (o_result_kind),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : result_sink
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                board.check_result(o_result_kind, o_out_byte, o_last_of_run);
            end
            if (holds_served < hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx * REG_STRIDE);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_cfg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic [7:0] data, input logic closed);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= data;
        i_stream_closed <= closed;
        do @(posedge i_clk); while (o_stall);
        board.note_item(data, closed);
    endtask

    task automatic wait_drained();
        while (board.expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly whole boundaries and near misses, so that matches and late mismatches occur often.
    task automatic send_traffic(input int count);
        int sent = 0;
        int len;
        int choice;
        int cut;
        logic [7:0] good;
        len = board.used_len();
        while (sent < count) begin
            choice = $urandom_range(99);
            if (choice < 4) begin
                send_item(8'($urandom_range(255)), 1'b1);
                sent++;
            end else if (choice < 50) begin
                send_item(DASH, 1'b0);
                send_item(DASH, 1'b0);
                for (int i = 0; i < len; i++) begin
                    send_item(board.bnd_byte(i), 1'b0);
                end
                sent += len + 2;
            end else if (choice < 70) begin
                cut = $urandom_range(len + 1);
                for (int i = 0; i < cut; i++) begin
                    send_item((i < 2) ? DASH : board.bnd_byte(i - 2), 1'b0);
                end
                good = (cut < 2) ? DASH : board.bnd_byte(cut - 2);
                send_item(~good, 1'b0);
                sent += cut + 1;
            end else begin
                cut = $urandom_range(1, 4);
                for (int i = 0; i < cut; i++) begin
                    send_item(($urandom_range(3) == 0) ? DASH : 8'($urandom_range(255)), 1'b0);
                end
                sent += cut;
            end
        end
        i_valid <= 1'b0;
    endtask

    task automatic run_phase(input int len_val, input logic keep, input t_boundary_style style,
                             input int tx_pct, input int rx_pct, input int count,
                             input bit squeeze);
        logic [DATA_W-1:0] word;
        for (int w = 0; w < BND_WORDS; w++) begin
            for (int b = 0; b < 8; b++) begin
                case (style)
                    STYLE_ZERO: begin
                        word[b * 8 +: 8] = 8'h00;
                    end
                    STYLE_ONES: begin
                        word[b * 8 +: 8] = 8'hFF;
                    end
                    STYLE_DASHES: begin
                        word[b * 8 +: 8] = ($urandom_range(2) != 0) ? DASH
                                                                     : 8'($urandom_range(255));
                    end
                    default: begin
                        word[b * 8 +: 8] = ($urandom_range(7) == 0) ? DASH
                                                                     : 8'($urandom_range(255));
                    end
                endcase
            end
            write_reg(REG_BND0 + w, word);
        end
        write_reg(REG_LEN, DATA_W'(len_val));
        write_reg(REG_KEEP, DATA_W'(keep));
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        if (squeeze) begin
            hold_requests++;
        end
        send_traffic(count);
        wait_drained();
    endtask

    initial begin : stimulus
        logic [8:0] opening [$];
        opening = '{9'h000, 9'h0FF, {1'b0, DASH}, {1'b0, DASH}, 9'h000,
                    9'h0FF, {1'b0, DASH}, CLOSE_ITEM,
                    {1'b0, DASH}, {1'b0, DASH}, {1'b0, DASH}, 9'h000,
                    CLOSE_ITEM | 9'h0FF,
                    9'h0A5, 9'h05A, {1'b0, DASH}, {1'b0, DASH}, 9'h001, 9'h0FF, CLOSE_ITEM};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset boundary is two dashes and one zero byte, with bytes kept.
        foreach (opening[k]) begin
            send_item(opening[k][7:0], opening[k][8]);
        end
        i_valid <= 1'b0;
        wait_drained();

        run_phase(8, 1'b1, STYLE_RANDOM, 0, 0, 70, 1'b0);
        run_phase(32, 1'b1, STYLE_ONES, 81, 0, 70, 1'b0);
        // The length shrinks here with bytes still held in the window.
        run_phase(3, 1'b0, STYLE_DASHES, 0, 81, 70, 1'b0);
        run_phase(0, 1'b1, STYLE_ZERO, 12, 12, 70, 1'b0);
        for (int idx = REG_KEEP + 1; idx < REG_SLOTS; idx++) begin
            write_reg(idx, {$urandom, $urandom});
        end
        run_phase(5, 1'b1, STYLE_RANDOM, 0, 0, 70, 1'b1);
        run_phase(63, 1'b0, STYLE_RANDOM, 12, 12, 60, 1'b0);
        run_phase(1, 1'b1, STYLE_DASHES, 81, 0, 60, 1'b0);
        run_phase(17, 1'b1, STYLE_RANDOM, 0, 81, 60, 1'b0);

        if (board.expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     board.expected_results.size());
        end
        $display("Run covered %0d items: %0d bytes passed, %0d boundaries found, %0d closes.",
                 board.items, board.bytes_passed, board.founds, board.ends);
        $display("Lengths 1 to 32 and out-of-range values, both keep modes, and a long hold.");
        if (board.errors == 0 && board.expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
